[design/cwcs_pkg.sv]
// Shared types and constants for the CSS whitespace and comment stripper.
// Used by the controller, the datapath and the top level; depends on nothing.
package cwcs_pkg;

  localparam int RUN_DEPTH_DEF = 32;

  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  typedef enum logic [1:0] {
    MODE_WRITE   = 2'd0,
    MODE_IGNORE  = 2'd1,
    MODE_COMMENT = 2'd2
  } mode_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;       // input beat taken this cycle
    logic load_flush;   // load held whitespace byte into the output register
    logic load_char;    // load the latched character into the output register
    logic load_end;     // load the end-only result and return to reset state
    logic idx_inc;      // advance the flush read index
    logic start_final;  // begin the end-of-text flush of the held run
  } cwcs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic emit_char;    // latched character is to be emitted
    logic last;         // latched beat closes the text
    logic idx_done;     // flush index has reached the flush length
    logic slot_free;    // output register can take a result this cycle
  } cwcs_status_t;

endpackage

[design/cwcs_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; used by the datapath to hold the whitespace run.
module cwcs_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[design/cwcs_ctrl.sv]
// Controller state machine that sequences flushes, character output and the end marker.
// Depends on cwcs_pkg for the command and status structs.
module cwcs_ctrl import cwcs_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  cwcs_status_t status,
  output cwcs_cmd_t    cmd
);

  typedef enum logic [4:0] {
    ST_IDLE     = 5'b00001,
    ST_FLUSH_RD = 5'b00010,
    ST_FLUSH_WR = 5'b00100,
    ST_CHAR     = 5'b01000,
    ST_END      = 5'b10000
  } state_t;

  state_t state, state_next;
  logic   final_phase, final_phase_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next       = state;
    final_phase_next = final_phase;
    cmd              = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept       = 1'b1;
          final_phase_next = 1'b0;
          state_next       = ST_FLUSH_RD;
        end
      end
      ST_FLUSH_RD: begin
        if (!status.idx_done) begin
          state_next = ST_FLUSH_WR;
        end else if (final_phase) begin
          state_next = ST_END;
        end else if (status.emit_char) begin
          state_next = ST_CHAR;
        end else if (status.last) begin
          cmd.start_final  = 1'b1;
          final_phase_next = 1'b1;
          state_next       = ST_FLUSH_RD;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_FLUSH_WR: begin
        if (status.slot_free) begin
          cmd.load_flush = 1'b1;
          cmd.idx_inc    = 1'b1;
          state_next     = ST_FLUSH_RD;
        end
      end
      ST_CHAR: begin
        if (status.slot_free) begin
          cmd.load_char = 1'b1;
          if (status.last) begin
            cmd.start_final  = 1'b1;
            final_phase_next = 1'b1;
            state_next       = ST_FLUSH_RD;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_END: begin
        if (status.slot_free) begin
          cmd.load_end = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      final_phase <= 1'b0;
    end else begin
      state       <= state_next;
      final_phase <= final_phase_next;
    end
  end

endmodule

[design/cwcs_dpath.sv]
// Datapath: byte decode, mode and lookahead registers, whitespace run store and output register.
// Depends on cwcs_pkg and cwcs_ram.
module cwcs_dpath import cwcs_pkg::*; #(
  parameter int RUN_DEPTH = RUN_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  cwcs_cmd_t    cmd,
  output cwcs_status_t status,
  input  logic [7:0]   char_byte,
  input  logic         last_char,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [7:0]   out_byte,
  output logic         has_byte,
  output logic         end_of_text,
  output logic         run_overflow
);

  localparam int AW = (RUN_DEPTH > 1) ? $clog2(RUN_DEPTH) : 1;
  localparam int CW = $clog2(RUN_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(RUN_DEPTH);

  mode_t       mode, mode_next;
  mode_t       saved_mode, saved_mode_next;
  logic        slash_pending, slash_pending_next;
  logic        star_pending, star_pending_next;
  logic        skip_one_space, skip_one_space_next;
  logic        overflow_flag, overflow_flag_next;
  logic [CW-1:0] held_count, held_count_next;
  logic [CW-1:0] flush_len, flush_len_next;
  logic [CW-1:0] idx;
  logic [7:0]  char_reg;
  logic        emit_reg, emit_next;
  logic        last_reg;
  logic        wr_en;
  logic        kind_rd;
  logic        ws, is_sp_tab, slot_free;

  assign is_sp_tab = (char_byte == CH_SPACE) || (char_byte == CH_TAB);
  assign ws        = is_sp_tab || (char_byte == CH_LF);
  assign slot_free = !out_valid || out_ready;

  // Decode of the incoming byte against the current mode and lookahead state.
  always_comb begin
    mode_next           = mode;
    saved_mode_next     = saved_mode;
    slash_pending_next  = 1'b0;
    star_pending_next   = 1'b0;
    skip_one_space_next = 1'b0;
    overflow_flag_next  = overflow_flag;
    held_count_next     = held_count;
    flush_len_next      = '0;
    emit_next           = 1'b0;
    wr_en               = 1'b0;

    if (slash_pending && char_byte == CH_STAR) begin
      saved_mode_next = mode;
      mode_next       = MODE_COMMENT;
    end
    if (star_pending && char_byte == CH_SLASH) begin
      mode_next = saved_mode;
    end

    if (!(skip_one_space && ws)) begin
      if (!ws && held_count != '0) begin
        held_count_next = '0;
        if (char_byte != CH_LBRACE) begin
          flush_len_next = held_count;
        end
      end
      case (char_byte)
        CH_LBRACE, CH_SEMI: begin
          if (mode_next != MODE_COMMENT) begin
            mode_next = MODE_IGNORE;
            emit_next = 1'b1;
          end
        end
        CH_RBRACE, CH_DOT, CH_HASH, CH_COLON: begin
          if (mode_next != MODE_COMMENT) begin
            mode_next           = MODE_WRITE;
            emit_next           = 1'b1;
            skip_one_space_next = (char_byte == CH_COLON);
          end
        end
        CH_LF, CH_CR: begin
        end
        CH_SLASH: begin
          slash_pending_next = 1'b1;
        end
        CH_STAR: begin
          star_pending_next = 1'b1;
        end
        default: begin
          if (mode_next != MODE_COMMENT) begin
            if (is_sp_tab) begin
              if (mode_next == MODE_WRITE) begin
                if (held_count < DEPTH_C) begin
                  wr_en           = 1'b1;
                  held_count_next = held_count + CW'(1);
                end else begin
                  overflow_flag_next = 1'b1;
                end
              end
            end else begin
              emit_next = 1'b1;
            end
          end
        end
      endcase
    end
  end

  cwcs_ram #(
    .WIDTH (1),
    .DEPTH (RUN_DEPTH)
  ) u_run (
    .clk     (clk),
    .wr_en   (cmd.accept && wr_en),
    .wr_addr (held_count[AW-1:0]),
    .wr_data (char_byte == CH_TAB),
    .rd_addr (idx[AW-1:0]),
    .rd_data (kind_rd)
  );

  always_ff @(posedge clk) begin
    if (rst || cmd.load_end) begin
      mode           <= MODE_WRITE;
      saved_mode     <= MODE_WRITE;
      slash_pending  <= 1'b0;
      star_pending   <= 1'b0;
      skip_one_space <= 1'b0;
      overflow_flag  <= 1'b0;
      held_count     <= '0;
      flush_len      <= '0;
      idx            <= '0;
    end else if (cmd.accept) begin
      mode           <= mode_next;
      saved_mode     <= saved_mode_next;
      slash_pending  <= slash_pending_next;
      star_pending   <= star_pending_next;
      skip_one_space <= skip_one_space_next;
      overflow_flag  <= overflow_flag_next;
      held_count     <= held_count_next;
      flush_len      <= flush_len_next;
      idx            <= '0;
    end else if (cmd.start_final) begin
      flush_len  <= held_count;
      held_count <= '0;
      idx        <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      char_reg <= char_byte;
      emit_reg <= emit_next;
      last_reg <= last_char;
    end
  end

  // Output register; the result fields are payload and need no reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_flush || cmd.load_char || cmd.load_end) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_flush) begin
      out_byte     <= kind_rd ? CH_TAB : CH_SPACE;
      has_byte     <= 1'b1;
      end_of_text  <= 1'b0;
      run_overflow <= overflow_flag;
    end else if (cmd.load_char) begin
      out_byte     <= char_reg;
      has_byte     <= 1'b1;
      end_of_text  <= 1'b0;
      run_overflow <= overflow_flag;
    end else if (cmd.load_end) begin
      out_byte     <= 8'h00;
      has_byte     <= 1'b0;
      end_of_text  <= 1'b1;
      run_overflow <= overflow_flag;
    end
  end

  assign status.emit_char = emit_reg;
  assign status.last      = last_reg;
  assign status.idx_done  = (idx == flush_len);
  assign status.slot_free = slot_free;

endmodule

[design/css_whitespace_comment_stripper.sv]
// Order: a taken beat moves the controller from ST_IDLE to ST_FLUSH_RD; each held whitespace
// byte flushed before it then passes ST_FLUSH_WR and ST_FLUSH_RD again (the run RAM has one
// registered read port), an emitted byte passes ST_CHAR, and the final byte flushes the run
// still held and loads the end marker in ST_END. A new byte is taken only in ST_IDLE.
// Reset: synchronous, active high; it empties the output register and returns to write mode.
// Depends on cwcs_pkg, cwcs_ctrl, cwcs_dpath and cwcs_ram.
module css_whitespace_comment_stripper import cwcs_pkg::*; #(
  parameter int RUN_DEPTH = RUN_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] char_byte,
  input  logic       last_char,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       has_byte,
  output logic       end_of_text,
  output logic       run_overflow
);

  // The controller takes one input beat at a time. After each beat the datapath has
  // latched the decoded byte and any run length that must be flushed before it.
  // The controller then walks the flush, the character itself, and on the final beat
  // the remaining run and the end-only result. Results leave through one output
  // register, so a stalled consumer only holds the controller in its current step.
  cwcs_cmd_t    cmd;
  cwcs_status_t status;

  cwcs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  cwcs_dpath #(
    .RUN_DEPTH (RUN_DEPTH)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .char_byte    (char_byte),
    .last_char    (last_char),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .has_byte     (has_byte),
    .end_of_text  (end_of_text),
    .run_overflow (run_overflow)
  );

endmodule

[tb/tb.sv]
// Self-checking testbench for css_whitespace_comment_stripper: directed and random CSS text.
// Predicts every output beat in its own model of the stripper and checks them in order.
// Depends on cwcs_pkg and the css_whitespace_comment_stripper RTL.
module tb;
  import cwcs_pkg::*;

  localparam int QUIET_LIMIT = 2000;   // cycles with no beat on either side before giving up
  localparam int TAIL_CYCLES = 100;    // settle time after the last expected beat
  localparam int RANDOM_ITEMS = 210;
  localparam int CALM_TAIL = 40;       // last input beats are sent with no idling at all
  localparam int LONG_HOLD = 150;      // one long receiver stall to back the block up
  localparam int LONG_HOLD_AT = 70;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } src_beat_t;

  typedef struct packed {
    logic [7:0] ob;
    logic       has;
    logic       eot;
    logic       ovf;
  } strip_beat_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] char_byte = 8'h00;
  logic       last_char = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       has_byte;
  logic       end_of_text;
  logic       run_overflow;

  // Pending source bytes, filled before reset is released, and the output beats that
  // the prediction says must come out, oldest first.
  src_beat_t   source_q[$];
  strip_beat_t stripped_q[$];
  logic [7:0]  text_buf[$];

  int total_items = 0;
  int beats_sent = 0;
  int beats_checked = 0;
  int texts_done = 0;
  int ovf_texts = 0;
  int errors = 0;

  always #6 clk = ~clk;

  css_whitespace_comment_stripper u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .char_byte   (char_byte),
    .last_char   (last_char),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .has_byte    (has_byte),
    .end_of_text (end_of_text),
    .run_overflow(run_overflow)
  );

  // ------------------------------------------------------------------------------------------
  // Prediction. This is an independent model of the stripper state: the current and saved
  // mode, the one-byte lookahead for comment delimiters, the swallow flag after a colon,
  // and the buffer of held spaces and tabs with its overflow flag.
  // ------------------------------------------------------------------------------------------
  mode_t cur_mode = MODE_WRITE;
  mode_t saved_mode = MODE_WRITE;
  logic  slash_seen = 1'b0;
  logic  star_seen = 1'b0;
  logic  skip_ws = 1'b0;
  logic  run_tab[RUN_DEPTH_DEF];
  int    run_len = 0;
  logic  ovf_seen = 1'b0;

  function automatic void expect_beat(logic [7:0] b, logic has, logic eot);
    strip_beat_t r;
    r.ob  = b;
    r.has = has;
    r.eot = eot;
    r.ovf = ovf_seen;
    stripped_q.push_back(r);
  endfunction

  function automatic void flush_run();
    for (int i = 0; i < run_len; i++)
      expect_beat(run_tab[i] ? CH_TAB : CH_SPACE, 1'b1, 1'b0);
    run_len = 0;
  endfunction

  function automatic void strip_byte(logic [7:0] c, logic last);
    logic ws;
    logic swallowed;
    ws = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF);
    swallowed = 1'b0;

    // The previous byte may have opened or closed a comment together with this one.
    if (slash_seen && c == CH_STAR) begin
      saved_mode = cur_mode;
      cur_mode = MODE_COMMENT;
    end
    if (star_seen && c == CH_SLASH)
      cur_mode = saved_mode;
    slash_seen = 1'b0;
    star_seen = 1'b0;

    if (skip_ws) begin
      skip_ws = 1'b0;
      swallowed = ws;
    end

    if (!swallowed) begin
      // A non-whitespace byte ends a held run; an opening brace throws the run away.
      if (!ws && run_len > 0) begin
        if (c != CH_LBRACE)
          flush_run();
        else
          run_len = 0;
      end
      case (c)
        CH_LBRACE, CH_SEMI: begin
          if (cur_mode != MODE_COMMENT) begin
            cur_mode = MODE_IGNORE;
            expect_beat(c, 1'b1, 1'b0);
          end
        end
        CH_RBRACE, CH_DOT, CH_HASH, CH_COLON: begin
          if (cur_mode != MODE_COMMENT) begin
            cur_mode = MODE_WRITE;
            expect_beat(c, 1'b1, 1'b0);
            if (c == CH_COLON)
              skip_ws = 1'b1;
          end
        end
        CH_LF, CH_CR: ;
        CH_SLASH: slash_seen = 1'b1;
        CH_STAR:  star_seen = 1'b1;
        default: begin
          if (cur_mode != MODE_COMMENT) begin
            if (c == CH_SPACE || c == CH_TAB) begin
              if (cur_mode == MODE_WRITE) begin
                if (run_len < RUN_DEPTH_DEF) begin
                  run_tab[run_len] = (c == CH_TAB);
                  run_len++;
                end else begin
                  ovf_seen = 1'b1;
                end
              end
            end else begin
              expect_beat(c, 1'b1, 1'b0);
            end
          end
        end
      endcase
    end

    // End of text: held whitespace goes out, then the end-only beat, then a clean slate.
    if (last) begin
      flush_run();
      expect_beat(8'h00, 1'b0, 1'b1);
      texts_done++;
      if (ovf_seen)
        ovf_texts++;
      cur_mode = MODE_WRITE;
      saved_mode = MODE_WRITE;
      slash_seen = 1'b0;
      star_seen = 1'b0;
      skip_ws = 1'b0;
      run_len = 0;
      ovf_seen = 1'b0;
    end
  endfunction

  // ------------------------------------------------------------------------------------------
  // Stimulus helpers. A text is assembled in text_buf and then queued with the final byte
  // marked as the end of the text.
  // ------------------------------------------------------------------------------------------
  task automatic add_byte(input logic [7:0] c, input logic last);
    src_beat_t s;
    s.ch = c;
    s.last = last;
    source_q.push_back(s);
  endtask

  task automatic put_word(input int len);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 3) == 0)
        text_buf.push_back(8'h30 + 8'($urandom_range(0, 9)));
      else
        text_buf.push_back(8'h61 + 8'($urandom_range(0, 25)));
    end
  endtask

  // Mostly spaces and tabs, with the odd line feed and carriage return mixed in.
  task automatic put_ws(input int len);
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 9))
        0:       text_buf.push_back(CH_LF);
        1:       text_buf.push_back(CH_CR);
        2, 3, 4: text_buf.push_back(CH_TAB);
        default: text_buf.push_back(CH_SPACE);
      endcase
    end
  endtask

  // One random text. Most pieces are well-formed CSS fragments with random content; some
  // are noise or broken comment delimiters. With force_long set, the text holds a run far
  // longer than the buffer between two plain bytes, so the flush is as large as it gets.
  task automatic build_text(input bit force_long);
    int pieces;
    text_buf.delete();
    if (force_long) begin
      text_buf.push_back(8'h61);
      for (int i = 0; i < 38; i++)
        text_buf.push_back($urandom_range(0, 1) ? CH_TAB : CH_SPACE);
      text_buf.push_back(8'h62);
    end else begin
      pieces = $urandom_range(2, 7);
      for (int k = 0; k < pieces; k++) begin
        case ($urandom_range(0, 9))
          0: begin
            text_buf.push_back($urandom_range(0, 1) ? CH_DOT : CH_HASH);
            put_word($urandom_range(1, 5));
            put_ws($urandom_range(0, 2));
            text_buf.push_back(CH_LBRACE);
          end
          1: begin
            put_word($urandom_range(1, 4));
            text_buf.push_back(CH_COLON);
            if ($urandom_range(0, 1))
              text_buf.push_back(CH_SPACE);
            put_word($urandom_range(1, 4));
            text_buf.push_back(CH_SEMI);
          end
          2: text_buf.push_back(CH_RBRACE);
          3: begin
            text_buf.push_back(CH_SLASH);
            text_buf.push_back(CH_STAR);
            put_word($urandom_range(0, 3));
            put_ws($urandom_range(0, 2));
            text_buf.push_back(CH_STAR);
            text_buf.push_back(CH_SLASH);
          end
          4: put_ws($urandom_range(1, 6));
          5: begin
            for (int i = $urandom_range(1, 3); i > 0; i--)
              text_buf.push_back(8'($urandom_range(0, 255)));
          end
          6: begin
            if ($urandom_range(0, 5) == 0)
              put_ws($urandom_range(33, 40));
            else
              put_ws($urandom_range(1, 3));
            put_word(1);
          end
          7: begin
            text_buf.push_back(CH_COLON);
            case ($urandom_range(0, 2))
              0:       text_buf.push_back(CH_LF);
              1:       text_buf.push_back(CH_TAB);
              default: text_buf.push_back(CH_SPACE);
            endcase
            put_ws($urandom_range(0, 1));
          end
          8: put_word($urandom_range(1, 6));
          default: begin
            text_buf.push_back($urandom_range(0, 1) ? CH_SLASH : CH_STAR);
            text_buf.push_back(8'($urandom_range(0, 255)));
          end
        endcase
      end
    end
    for (int k = 0; k < text_buf.size(); k++)
      add_byte(text_buf[k], k == text_buf.size() - 1);
  endtask

  // Idling comes in phases: none, sparse and dense, and none at all near the end.
  function automatic int idle_level();
    if (beats_sent + CALM_TAIL >= total_items)
      return 0;
    return (beats_sent / 25) % 3;
  endfunction

  function automatic bit idle_roll(input int one_in_sparse, input int one_in_dense);
    case (idle_level())
      1:       return $urandom_range(1, one_in_sparse) == 1;
      2:       return $urandom_range(1, one_in_dense) == 1;
      default: return 1'b0;
    endcase
  endfunction

  // ------------------------------------------------------------------------------------------
  // Driver. Valid is raised when a byte is available and no random idle gap is running, and
  // held until the beat is taken. Each accepted beat is run through the prediction at the edge it is taken.
  // ------------------------------------------------------------------------------------------
  int        send_gap = 0;
  bit        fire_in;
  src_beat_t next_src;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      fire_in = in_valid && in_ready;
      if (fire_in) begin
        strip_byte(char_byte, last_char);
        beats_sent++;
        if (idle_roll(8, 3))
          send_gap = $urandom_range(1, 9);
      end
      if (!in_valid || fire_in) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (source_q.size() > 0) begin
          next_src = source_q.pop_front();
          in_valid <= 1'b1;
          char_byte <= next_src.ch;
          last_char <= next_src.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ------------------------------------------------------------------------------------------
  // Monitor. Every accepted output beat is compared with the oldest expected beat. Ready is
  // dropped in short random bursts, and once for a long stretch while the driver keeps
  // offering bytes, so the block has to fill up and push back on its input.
  // ------------------------------------------------------------------------------------------
  int          hold_left = 0;
  bit          long_hold_done = 1'b0;
  strip_beat_t want;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        beats_checked++;
        if (stripped_q.size() == 0) begin
          $error("unexpected output beat: out_byte=%h has_byte=%b end_of_text=%b run_overflow=%b",
                 out_byte, has_byte, end_of_text, run_overflow);
          errors++;
        end else begin
          want = stripped_q.pop_front();
          if (out_byte !== want.ob) begin
            $error("out_byte: expected %h, got %h", want.ob, out_byte);
            errors++;
          end
          if (has_byte !== want.has) begin
            $error("has_byte: expected %b, got %b", want.has, has_byte);
            errors++;
          end
          if (end_of_text !== want.eot) begin
            $error("end_of_text: expected %b, got %b", want.eot, end_of_text);
            errors++;
          end
          if (run_overflow !== want.ovf) begin
            $error("run_overflow: expected %b, got %b", want.ovf, run_overflow);
            errors++;
          end
        end
      end

      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!long_hold_done && beats_sent >= LONG_HOLD_AT) begin
        long_hold_done = 1'b1;
        hold_left = LONG_HOLD - 1;
        out_ready <= 1'b0;
      end else if (idle_roll(10, 4)) begin
        hold_left = $urandom_range(1, 9) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: a stretch with no beat accepted on either side means the block is stuck.
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no beat accepted for %0d cycles, %0d beats still expected",
               QUIET_LIMIT, stripped_q.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ------------------------------------------------------------------------------------------
  // Test sequence.
  // ------------------------------------------------------------------------------------------
  initial begin
    // Directed text: extreme byte values, every mode-changing character, a run discarded by
    // an opening brace, the swallowed space after a colon, a comment, a line feed skipped
    // inside a run, a carriage return ending a run, and a space held until the text ends.
    add_byte(8'h00, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(CH_DOT, 1'b0);
    add_byte(8'h61, 1'b0);
    add_byte(CH_SPACE, 1'b0);
    add_byte(CH_TAB, 1'b0);
    add_byte(CH_LBRACE, 1'b0);
    add_byte(8'h63, 1'b0);
    add_byte(CH_COLON, 1'b0);
    add_byte(CH_SPACE, 1'b0);
    add_byte(8'h78, 1'b0);
    add_byte(CH_SEMI, 1'b0);
    add_byte(CH_SLASH, 1'b0);
    add_byte(CH_STAR, 1'b0);
    add_byte(8'h7A, 1'b0);
    add_byte(CH_STAR, 1'b0);
    add_byte(CH_SLASH, 1'b0);
    add_byte(CH_RBRACE, 1'b0);
    add_byte(CH_TAB, 1'b0);
    add_byte(CH_LF, 1'b0);
    add_byte(CH_SPACE, 1'b0);
    add_byte(CH_CR, 1'b0);
    add_byte(CH_HASH, 1'b0);
    add_byte(CH_SPACE, 1'b1);
    // A text that ends on a lone slash: the pending delimiter must leave no trace.
    add_byte(CH_SLASH, 1'b1);

    // Random texts, the first with the largest possible flush and an overflowing run.
    build_text(1'b1);
    while (source_q.size() < RANDOM_ITEMS)
      build_text(1'b0);
    total_items = source_q.size();

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (beats_sent < total_items)
      @(posedge clk);
    while (stripped_q.size() > 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d bytes in %0d texts and checked %0d output beats.",
             beats_sent, texts_done, beats_checked);
    $display("%0d texts overflowed the whitespace run buffer; %0d mismatches.",
             ovf_texts, errors);
    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

[filelist.f]
design/cwcs_pkg.sv
design/cwcs_ram.sv
design/cwcs_ctrl.sv
design/cwcs_dpath.sv
design/css_whitespace_comment_stripper.sv
tb/tb.sv
